[src/hse_pkg.sv]
// Shared types and constants for the Hamming(31,26) stream encoder.
// No dependencies; every other file in src imports this package.
`default_nettype none

package hse_pkg;

	localparam int DATA_BITS   = 26;
	localparam int CODE_BITS   = 31;
	localparam int PAR_BITS    = 5;
	localparam int BYTE_BITS   = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input word: one raw data byte, bit 7 first
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	// Output word: one byte of the packed codeword stream
	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_out;
	} out_word_t;

	// Queue entry: one 26-bit data block, flagged when it closes a message
	typedef struct packed {
		logic [DATA_BITS-1:0] block;
		logic                 last;
	} blk_entry_t;

endpackage

`default_nettype wire

[src/hse_front.sv]
// Front end: collects data bytes into 26-bit blocks and pads the final block.
// Depends on hse_pkg; feeds hse_queue.
`default_nettype none

module hse_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire hse_pkg::in_word_t  in_word,
	output logic                    push,
	output hse_pkg::blk_entry_t     push_entry,
	input  wire logic               q_full
);
	import hse_pkg::*;

	logic [DATA_BITS-2:0] acc_q;
	logic [4:0]           cnt_q;
	logic                 pend_q;
	blk_entry_t           pend_entry_q;

	logic                 accept;
	logic [DATA_BITS+6:0] t;
	logic [5:0]           n;
	logic                 full;
	logic [5:0]           rest;
	logic [2:0]           rest3;
	logic [DATA_BITS-1:0] blk_full;
	logic [DATA_BITS-2:0] rem;
	logic [4:0]           rem_n;
	logic [DATA_BITS-1:0] blk_part;
	logic [DATA_BITS+6:0] rest_mask;

	assign in_stall = pend_q || q_full;
	assign accept   = in_valid && !in_stall;

	// Append the byte and split off a full block when one is complete
	always_comb begin
		t         = {acc_q, in_word.data_byte};
		n         = {1'b0, cnt_q} + 6'd8;
		full      = (n >= 6'(DATA_BITS));
		rest      = n - 6'(DATA_BITS);
		rest3     = rest[2:0];
		rest_mask = (33'd1 << rest3) - 33'd1;
		blk_full  = DATA_BITS'(t >> rest3);
		if (full) begin
			rem   = (DATA_BITS-1)'(t & rest_mask);
			rem_n = {2'b00, rest3};
		end else begin
			rem   = t[DATA_BITS-2:0];
			rem_n = n[4:0];
		end
		// zero-pad the leftover bits into a last block
		blk_part = {1'b0, rem} << (5'(DATA_BITS) - rem_n);
	end

	// Queue push: a held second block goes first, else the current word's block
	always_comb begin
		push       = 1'b0;
		push_entry = '{block: blk_full, last: 1'b0};
		if (pend_q) begin
			push       = !q_full;
			push_entry = pend_entry_q;
		end else if (accept) begin
			if (full) begin
				push       = 1'b1;
				push_entry = '{block: blk_full,
					last: in_word.last_byte && (rem_n == 5'd0)};
			end else if (in_word.last_byte) begin
				push       = 1'b1;
				push_entry = '{block: blk_part, last: 1'b1};
			end
		end
	end

	// Accumulator and held block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !q_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (in_word.last_byte) begin
					acc_q  <= '0;
					cnt_q  <= '0;
					pend_q <= full && (rem_n != 5'd0);
				end else begin
					acc_q <= rem;
					cnt_q <= rem_n;
				end
			end
		end
	end

	// Second block of a final word, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_entry_q <= '{block: blk_part, last: 1'b1};
		end
	end

endmodule

`default_nettype wire

[src/hse_queue.sv]
// Short block queue between front end and serializer.
// Depends on hse_pkg.
`default_nettype none

module hse_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire hse_pkg::blk_entry_t  push_entry,
	input  wire logic                 pop,
	output hse_pkg::blk_entry_t       head,
	output logic                      empty,
	output logic                      full
);
	import hse_pkg::*;

	blk_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/hse_back.sv]
// Back end: encodes queued blocks into 31-bit codewords and serializes bytes.
// Depends on hse_pkg; reads from hse_queue.
`default_nettype none

module hse_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  wire hse_pkg::blk_entry_t  q_head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output hse_pkg::out_word_t        out_word
);
	import hse_pkg::*;

	localparam int BUF_W = CODE_BITS + BYTE_BITS - 1;

	// Place data bits where p+1 is not a power of two, then set even parity bits.
	// Position p is bit CODE_BITS-1-p, so position 0 goes out first.
	function automatic logic [CODE_BITS-1:0] encode_cw(input logic [DATA_BITS-1:0] blk);
		logic [CODE_BITS-1:0] cw;
		logic [CODE_BITS-1:0] cov;
		int                   d;
		cw = '0;
		d  = 0;
		for (int p = 0; p < CODE_BITS; p++) begin
			if (((p + 1) & p) != 0) begin
				cw[CODE_BITS-1-p] = blk[DATA_BITS-1-d];
				d++;
			end
		end
		for (int k = 0; k < PAR_BITS; k++) begin
			cov = '0;
			for (int p = 0; p < CODE_BITS; p++) begin
				if ((((p + 1) >> k) & 1) != 0) begin
					cov[CODE_BITS-1-p] = 1'b1;
				end
			end
			cw[CODE_BITS-1-((1 << k) - 1)] = ^(cw & cov);
		end
		return cw;
	endfunction

	logic [BUF_W-1:0] buf_q;
	logic [5:0]       bcnt_q;
	logic             flush_q;
	logic             ov_q;
	out_word_t        ow_q;

	logic             slot_free;
	logic             can_emit;
	logic             emit;
	logic             whole;
	logic [2:0]       pad_sh;
	logic [7:0]       byte_val;
	logic             byte_last;

	assign out_valid = ov_q;
	assign out_word  = ow_q;

	// Emit a byte when one is whole, or the padded tail of a message
	always_comb begin
		slot_free = !ov_q || !out_stall;
		whole     = (bcnt_q >= 6'd8);
		can_emit  = whole || (flush_q && (bcnt_q != 6'd0));
		emit      = slot_free && can_emit;
		pop       = !whole && !flush_q && !q_empty;
		pad_sh    = 3'(4'd8 - {1'b0, bcnt_q[2:0]});
		if (whole) begin
			byte_val = 8'(buf_q >> (bcnt_q - 6'd8));
		end else begin
			byte_val = buf_q[7:0] << pad_sh;
		end
		byte_last = flush_q && (bcnt_q <= 6'd8);
	end

	// Bit buffer: valid bits are the low bcnt_q bits, oldest on top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q  <= '0;
			flush_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (pop) begin
				bcnt_q  <= bcnt_q + 6'(CODE_BITS);
				flush_q <= q_head.last;
			end else if (emit) begin
				bcnt_q <= whole ? (bcnt_q - 6'd8) : 6'd0;
				if (byte_last) begin
					flush_q <= 1'b0;
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q <= {buf_q[BYTE_BITS-2:0], encode_cw(q_head.block)};
		end
		if (emit) begin
			ow_q <= '{code_byte: byte_val, last_out: byte_last};
		end
	end

endmodule

`default_nettype wire

[src/hamming_31_26_stream_encoder_top.sv]
// Streaming Hamming(31,26) encoder. A byte word on the ingress side is taken
// whenever ingress_stall is low; ingress_stall rises only while the four-entry
// block queue is full or while a padded partial block waits to be pushed after
// a final byte that closes a full block and also leaves that partial block
// behind. Each 26 data bits (MSB first) become one 31-bit codeword with
// even parity at positions 0, 1, 3, 7 and 15, sent position 0 first as a
// continuous bit stream packed into bytes. The serializer loads a codeword
// only while fewer than eight stream bits are buffered and sends no byte
// while it loads; a final byte adds one padded codeword when data bits remain
// and a padded tail byte when stream bits remain. The final output byte of a
// message carries last_out.
// Depends on hse_pkg, hse_front, hse_queue and hse_back.
`default_nettype none

module hamming_31_26_stream_encoder_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ingress_valid,
	output logic                    ingress_stall,
	input  wire hse_pkg::in_word_t  ingress_word,
	output logic                    egress_valid,
	input  wire logic               egress_stall,
	output hse_pkg::out_word_t      egress_word
);
	import hse_pkg::*;

	logic       push;
	blk_entry_t push_entry;
	logic       pop;
	blk_entry_t q_head;
	logic       q_empty;
	logic       q_full;

	// Byte collection and block padding
	hse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ingress_valid),
		.in_stall   (ingress_stall),
		.in_word    (ingress_word),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Decoupling queue
	hse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Encoding and byte serialization
	hse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (egress_valid),
		.out_stall (egress_stall),
		.out_word  (egress_word)
	);

endmodule

`default_nettype wire
